// ===== hw/rtl/vrp_pkg.sv =====
package vrp_pkg;

  localparam int unsigned AngleW = 9;
  localparam int unsigned CoordW = 16;
  localparam int unsigned TrigW  = 14;
  localparam int unsigned ScreenW = 11;

  typedef enum logic [1:0] {
    RegAngleX = 2'd0,
    RegAngleY = 2'd1,
    RegAngleZ = 2'd2
  } reg_idx_e;

  localparam logic [31:0] TrigA = 32'd3370945099;
  localparam logic [31:0] TrigB = 32'd2746362156;
  localparam logic [31:0] TrigC = 32'd292421;
  localparam logic [15:0] QuarterTurn = 16'd8192;
  localparam logic signed [ScreenW-1:0] CenterX = 11'sd320;
  localparam logic signed [ScreenW-1:0] CenterY = 11'sd180;

  typedef struct packed {
    logic signed [CoordW-1:0] vertex_x;
    logic signed [CoordW-1:0] vertex_y;
    logic signed [CoordW-1:0] vertex_z;
  } vertex_t;

  typedef struct packed {
    logic signed [ScreenW-1:0] screen_x;
    logic signed [ScreenW-1:0] screen_y;
  } screen_t;

  typedef struct packed {
    logic signed [TrigW-1:0] sin_v;
    logic signed [TrigW-1:0] cos_v;
  } trig_t;

endpackage

// ===== hw/rtl/vrp_stream_if.sv =====
interface vrp_stream_if #(
  parameter int unsigned Width = 48
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/vertex_rotate_project_core.sv =====
// Channel   Dir  Payload
// vtx_in    in   vertex_x, vertex_y, vertex_z (16b signed each)
// scr_out   out  screen_x, screen_y (11b signed each)
// One vertex per cycle unless stalled; stages X rotate, Y rotate, Z rotate,
// then project into the output register, one multiply per product per stage.
// A stall freezes every stage; ready follows the output stage being free.
// Sine/cosine pipelines settle after reset or an angle write.
module vertex_rotate_project_core
  import vrp_pkg::*;
#(
  parameter int unsigned ANGLE_STEPS = 360
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [8:0]   cfg_data_i,
  vrp_stream_if.sink   vtx_in,
  vrp_stream_if.source scr_out
);

  logic [AngleW-1:0] ang_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) ang_q[i] <= 9'd10;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegAngleX: ang_q[0] <= cfg_data_i;
        RegAngleY: ang_q[1] <= cfg_data_i;
        RegAngleZ: ang_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  trig_t tr [3];
  for (genvar a = 0; a < 3; a++) begin : g_trig
    vrp_trig #(.AngleSteps(ANGLE_STEPS)) u_trig (
      .clk_i, .rst_ni, .angle_i(ang_q[a]), .trig_o(tr[a]));
  end

  function automatic logic signed [15:0] sarw(input logic signed [31:0] v);
    return v[27:12];
  endfunction

  logic adv;
  logic v1_q, v2_q, v3_q, v4_q;
  assign adv = !v4_q || scr_out.ready;
  assign vtx_in.ready = adv;

  vertex_t vin;
  assign vin = vertex_t'(vtx_in.data);

  logic signed [15:0] x1_q, y1_q, z1_q, x2_q, y2_q, x3_q, y3_q;
  screen_t out_q;

  logic signed [15:0] px, py;
  assign px = x3_q / 16'sd64;
  assign py = y3_q / 16'sd64;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= vtx_in.valid; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x1_q <= vin.vertex_x;
      y1_q <= sarw(32'(vin.vertex_y) * 32'(tr[0].cos_v)
                 - 32'(vin.vertex_z) * 32'(tr[0].sin_v));
      z1_q <= sarw(32'(vin.vertex_y) * 32'(tr[0].sin_v)
                 + 32'(vin.vertex_z) * 32'(tr[0].cos_v));
      x2_q <= sarw(32'(x1_q) * 32'(tr[1].cos_v) + 32'(z1_q) * 32'(tr[1].sin_v));
      y2_q <= y1_q;
      x3_q <= sarw(32'(x2_q) * 32'(tr[2].cos_v) - 32'(y2_q) * 32'(tr[2].sin_v));
      y3_q <= sarw(32'(x2_q) * 32'(tr[2].sin_v) + 32'(y2_q) * 32'(tr[2].cos_v));
      out_q.screen_x <= ScreenW'(px) + CenterX;
      out_q.screen_y <= ScreenW'(py) + CenterY;
    end
  end

  assign scr_out.valid = v4_q;
  assign scr_out.data  = out_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && !scr_out.ready |=> v4_q && $stable(out_q))
    else $error("result dropped during stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v4_q |-> vtx_in.ready)
    else $error("empty output stage blocks input");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vtx_in.valid && vtx_in.ready |=> v1_q)
    else $error("accepted vertex lost");

endmodule

// ===== hw/rtl/vrp_trig.sv =====
// Sine/cosine of one angle register, rerun in its own polynomial pipeline
// on angle change. The user keeps config static while busy; unchecked.
module vrp_trig
  import vrp_pkg::*;
#(
  parameter int unsigned AngleSteps = 360
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [AngleW-1:0] angle_i,
  output trig_t             trig_o
);

  localparam logic [15:0] Step = 16'(32768 / AngleSteps);

  logic [15:0] phase;
  logic [31:0] mul;
  assign mul   = 32'(angle_i) * 32'(Step);
  assign phase = mul[15:0];

  // one polynomial lane per output; each stage one 32-bit multiply
  logic [14:0] t_q   [2];
  logic        neg_q [2];
  logic [31:0] y1_q  [2];
  logic [31:0] y2_q  [2];
  logic [31:0] y3_q  [2];
  logic [31:0] y4_q  [2];
  logic [14:0] t2_q  [2], t3_q [2], t4_q [2], t5_q [2];
  logic        n2_q  [2], n3_q [2], n4_q [2], n5_q [2];
  logic [15:0] res   [2];

  for (genvar g = 0; g < 2; g++) begin : g_lane
    logic [15:0] ph, u, uf;
    logic [31:0] r;
    assign ph = (g == 0) ? phase : phase + QuarterTurn;
    assign u  = {ph[14:0], 1'b0};
    assign uf = u[14] ? 16'h8000 - u : u;

    always_ff @(posedge clk_i) begin
      t_q[g]  <= uf[15:1] & 15'h3fff;
      neg_q[g] <= u[15];
      y1_q[g] <= (TrigC * 32'({1'b0, uf[14:1]})) >> 13;
      t2_q[g] <= t_q[g];   n2_q[g] <= neg_q[g];
      y2_q[g] <= TrigB - ((32'(t_q[g]) * y1_q[g]) >> 3);
      t3_q[g] <= t2_q[g];  n3_q[g] <= n2_q[g];
      y3_q[g] <= 32'(t2_q[g]) * (y2_q[g] >> 13);
      t4_q[g] <= t3_q[g];  n4_q[g] <= n3_q[g];
      y4_q[g] <= TrigA - ((32'(t3_q[g]) * (y3_q[g] >> 13)) >> 1);
      t5_q[g] <= t4_q[g];  n5_q[g] <= n4_q[g];
    end

    always_comb begin
      r = 32'(t5_q[g]) * (y4_q[g] >> 13);
      r = (r + 32'h4_0000) >> 19;
      if (n5_q[g]) r = 32'd0 - r;
      res[g] = r[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_o <= '0;
    end else begin
      trig_o.sin_v <= TrigW'(res[0]);
      trig_o.cos_v <= TrigW'(res[1]);
    end
  end

endmodule
